// ===== design/r2y_pkg.sv =====
// ----------------------------------------------------------------------------
// r2y_pkg
// Shared constants and stage types for the RGB24 to YUV 4:2:0 converter.
// ----------------------------------------------------------------------------
`default_nettype none

package r2y_pkg;

  // Frame size limits
  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;

  // One upper-line entry per horizontal pixel pair
  localparam int PAIR_DEPTH = (MAX_WIDTH + 1) / 2;
  localparam int SLOT_W     = $clog2(PAIR_DEPTH);

  // Position counters and effective sizes
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int LINE_W  = $clog2(MAX_HEIGHT);
  localparam int WSZ_W   = COL_W + 1;
  localparam int HSZ_W   = LINE_W + 1;

  // Configuration registers
  localparam int CFG_W       = 12;
  localparam int APB_ADDR_W  = 3;
  localparam int APB_DATA_W  = 32;
  localparam logic [CFG_W-1:0] WIDTH_RST  = 12'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RST = 12'd480;
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  // Sample and sum widths
  localparam int PIX_W  = 8;
  localparam int PSUM_W = PIX_W + 1;  // sum of two samples
  localparam int QSUM_W = PIX_W + 2;  // sum of four samples
  localparam int PAIR_W = 3 * PSUM_W; // packed r/g/b pair sums

  // Stream payload widths
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 24;

  // Accept stage -> arithmetic stage
  typedef struct packed {
    logic [PIX_W-1:0]  red;
    logic [PIX_W-1:0]  green;
    logic [PIX_W-1:0]  blue;
    logic [PSUM_W-1:0] sum_r;   // left + right of the pair
    logic [PSUM_W-1:0] sum_g;
    logic [PSUM_W-1:0] sum_b;
    logic              chroma;  // lower-right pixel of a 2x2 block
    logic              last;
  } s1_t;

  // Arithmetic stage -> chroma stage
  typedef struct packed {
    logic [PIX_W-1:0] luma;
    logic [PIX_W-1:0] avg_r;
    logic [PIX_W-1:0] avg_g;
    logic [PIX_W-1:0] avg_b;
    logic             chroma;
    logic             last;
  } s2_t;

endpackage

`default_nettype wire

// ===== design/rgb24_to_yuv420_converter.sv =====
// ----------------------------------------------------------------------------
// rgb24_to_yuv420_converter
// BT.601 integer RGB24 to YUV 4:2:0 conversion, one result beat per pixel.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels enter in raster order on the in_ stream (one RGB beat per pixel)
//   and leave on the out_ stream as one beat per pixel carrying luma. On the
//   lower-right pixel of each 2x2 block out_tuser is set and the beat also
//   carries the block's U and V; otherwise U and V read as zero. out_tlast
//   marks the final pixel of the frame. Frame width and height are set over
//   the APB-style cfg_ port (offsets 0x0 and 0x4) while the stream is idle.
//   Throughput: one pixel per clock while the output is not stalled. An
//   accepted pixel passes the accept register, the luma/average register
//   and the output register in turn before it shows on out_tvalid. At most
//   one line-buffer access per pixel (write of the upper pair, or read of it
//   for the lower pair) fits in this pipeline; the handshake sets the rate.
//   Reset clears position counters, pipeline valids and restores width 640
//   and height 480; the line buffer needs no clearing since every entry is
//   written on an upper line before it is read.
//   When the receiver stalls with a finished beat in the output register,
//   the whole pipeline holds; in_tready drops only in that case.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb24_to_yuv420_converter (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // input pixel stream
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [r2y_pkg::IN_DATA_W-1:0]     in_tdata,   // red, green, blue
  // result stream
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic      [r2y_pkg::OUT_DATA_W-1:0]    out_tdata,  // luma, chroma_u, chroma_v
  output logic                                   out_tuser,  // chroma_valid
  output logic                                   out_tlast,  // frame_last
  // configuration port
  input  wire logic                              cfg_psel,
  input  wire logic                              cfg_penable,
  input  wire logic                              cfg_pwrite,
  input  wire logic [r2y_pkg::APB_ADDR_W-1:0]    cfg_paddr,
  input  wire logic [r2y_pkg::APB_DATA_W-1:0]    cfg_pwdata,
  output logic      [r2y_pkg::APB_DATA_W-1:0]    cfg_prdata,
  output logic                                   cfg_pready
);

  localparam int PW = r2y_pkg::PIX_W;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [r2y_pkg::CFG_W-1:0] frame_width_r;
  logic [r2y_pkg::CFG_W-1:0] frame_height_r;
  logic                      cfg_wr;
  logic                      cfg_sel;

  assign cfg_pready = 1'b1;
  assign cfg_sel    = cfg_paddr[2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= r2y_pkg::WIDTH_RST;
      frame_height_r <= r2y_pkg::HEIGHT_RST;
    end else if (cfg_wr) begin
      if (cfg_sel == r2y_pkg::REG_FRAME_WIDTH) begin
        frame_width_r <= cfg_pwdata[r2y_pkg::CFG_W-1:0];
      end else begin
        frame_height_r <= cfg_pwdata[r2y_pkg::CFG_W-1:0];
      end
    end
  end

  always_comb begin
    if (cfg_sel == r2y_pkg::REG_FRAME_WIDTH) begin
      cfg_prdata = r2y_pkg::APB_DATA_W'(frame_width_r);
    end else begin
      cfg_prdata = r2y_pkg::APB_DATA_W'(frame_height_r);
    end
  end

  // effective sizes: zero acts as one, oversize clamps to the maximum
  logic [r2y_pkg::WSZ_W-1:0] w_eff;
  logic [r2y_pkg::HSZ_W-1:0] h_eff;

  always_comb begin
    if (frame_width_r == '0) begin
      w_eff = r2y_pkg::WSZ_W'(1);
    end else if (32'(frame_width_r) > 32'(r2y_pkg::MAX_WIDTH)) begin
      w_eff = r2y_pkg::WSZ_W'(r2y_pkg::MAX_WIDTH);
    end else begin
      w_eff = r2y_pkg::WSZ_W'(frame_width_r);
    end
    if (frame_height_r == '0) begin
      h_eff = r2y_pkg::HSZ_W'(1);
    end else if (32'(frame_height_r) > 32'(r2y_pkg::MAX_HEIGHT)) begin
      h_eff = r2y_pkg::HSZ_W'(r2y_pkg::MAX_HEIGHT);
    end else begin
      h_eff = r2y_pkg::HSZ_W'(frame_height_r);
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake: whole pipeline advances unless the output beat is stuck
  // ---------------------------------------------------------------------------
  logic out_valid_r;
  logic adv;
  logic accept;

  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv;
  assign accept    = in_tvalid && adv;

  // ---------------------------------------------------------------------------
  // Position tracking
  // ---------------------------------------------------------------------------
  logic [r2y_pkg::COL_W-1:0]  col_cnt_r, col_cnt_nxt, col;
  logic [r2y_pkg::LINE_W-1:0] line_cnt_r, line_cnt_nxt, line;
  logic [r2y_pkg::WSZ_W-1:0]  col_inc;
  logic [r2y_pkg::HSZ_W-1:0]  line_inc;
  logic                       is_last;

  always_comb begin
    // wrap at once if the size shrank below the current position
    col  = (r2y_pkg::WSZ_W'(col_cnt_r)  >= w_eff) ? '0 : col_cnt_r;
    line = (r2y_pkg::HSZ_W'(line_cnt_r) >= h_eff) ? '0 : line_cnt_r;
    col_inc  = r2y_pkg::WSZ_W'(col) + r2y_pkg::WSZ_W'(1);
    line_inc = r2y_pkg::HSZ_W'(line) + r2y_pkg::HSZ_W'(1);
    is_last  = (col_inc == w_eff) && (line_inc == h_eff);
    if (col_inc >= w_eff) begin
      col_cnt_nxt  = '0;
      line_cnt_nxt = (line_inc >= h_eff) ? '0 : line_inc[r2y_pkg::LINE_W-1:0];
    end else begin
      col_cnt_nxt  = col_inc[r2y_pkg::COL_W-1:0];
      line_cnt_nxt = line;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r  <= '0;
      line_cnt_r <= '0;
    end else if (accept) begin
      col_cnt_r  <= col_cnt_nxt;
      line_cnt_r <= line_cnt_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Pair sums and upper-line buffer
  // ---------------------------------------------------------------------------
  logic [PW-1:0] in_r, in_g, in_b;
  logic [3*PW-1:0] left_hold_r;
  logic [r2y_pkg::PSUM_W-1:0] pair_r, pair_g, pair_b;
  logic odd_col, odd_line;
  logic buf_we, buf_re;
  logic [r2y_pkg::SLOT_W-1:0] slot;
  logic [r2y_pkg::PAIR_W-1:0] upper_rd;

  assign in_r     = in_tdata[PW-1:0];
  assign in_g     = in_tdata[2*PW-1:PW];
  assign in_b     = in_tdata[3*PW-1:2*PW];
  assign odd_col  = col[0];
  assign odd_line = line[0];
  assign slot     = r2y_pkg::SLOT_W'(col >> 1);

  assign pair_r = r2y_pkg::PSUM_W'(left_hold_r[PW-1:0])      + r2y_pkg::PSUM_W'(in_r);
  assign pair_g = r2y_pkg::PSUM_W'(left_hold_r[2*PW-1:PW])   + r2y_pkg::PSUM_W'(in_g);
  assign pair_b = r2y_pkg::PSUM_W'(left_hold_r[3*PW-1:2*PW]) + r2y_pkg::PSUM_W'(in_b);

  assign buf_we = accept && odd_col && !odd_line;
  assign buf_re = accept && odd_col && odd_line;

  // left pixel of the current pair
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_hold_r <= '0;
    end else if (accept && !odd_col) begin
      left_hold_r <= in_tdata[3*PW-1:0];
    end
  end

  r2y_ram #(
    .WIDTH (r2y_pkg::PAIR_W),
    .DEPTH (r2y_pkg::PAIR_DEPTH)
  ) u_upper_buf (
    .clk   (clk),
    .we    (buf_we),
    .waddr (slot),
    .wdata ({pair_b, pair_g, pair_r}),
    .re    (buf_re),
    .raddr (slot),
    .rdata (upper_rd)
  );

  // ---------------------------------------------------------------------------
  // Stage 1: accepted pixel
  // ---------------------------------------------------------------------------
  r2y_pkg::s1_t s1_r, s1_nxt;
  logic         s1_valid_r;

  always_comb begin
    s1_nxt.red    = in_r;
    s1_nxt.green  = in_g;
    s1_nxt.blue   = in_b;
    s1_nxt.sum_r  = pair_r;
    s1_nxt.sum_g  = pair_g;
    s1_nxt.sum_b  = pair_b;
    s1_nxt.chroma = odd_col && odd_line;
    s1_nxt.last   = is_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r <= s1_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: luma and 2x2 averages
  // ---------------------------------------------------------------------------
  r2y_pkg::s2_t s2_r, s2_nxt;
  logic         s2_valid_r;
  logic [15:0]  y_acc;
  logic [r2y_pkg::QSUM_W-1:0] q_r, q_g, q_b;

  always_comb begin
    y_acc = 16'd66 * 16'(s1_r.red) + 16'd129 * 16'(s1_r.green)
          + 16'd25 * 16'(s1_r.blue) + 16'd128;
    q_r = r2y_pkg::QSUM_W'(s1_r.sum_r)
        + r2y_pkg::QSUM_W'(upper_rd[r2y_pkg::PSUM_W-1:0]);
    q_g = r2y_pkg::QSUM_W'(s1_r.sum_g)
        + r2y_pkg::QSUM_W'(upper_rd[2*r2y_pkg::PSUM_W-1:r2y_pkg::PSUM_W]);
    q_b = r2y_pkg::QSUM_W'(s1_r.sum_b)
        + r2y_pkg::QSUM_W'(upper_rd[3*r2y_pkg::PSUM_W-1:2*r2y_pkg::PSUM_W]);
    s2_nxt.luma   = y_acc[15:8] + 8'd16;
    s2_nxt.avg_r  = q_r[r2y_pkg::QSUM_W-1:2];
    s2_nxt.avg_g  = q_g[r2y_pkg::QSUM_W-1:2];
    s2_nxt.avg_b  = q_b[r2y_pkg::QSUM_W-1:2];
    s2_nxt.chroma = s1_r.chroma;
    s2_nxt.last   = s1_r.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid_r) begin
      s2_r <= s2_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: chroma and output register
  // ---------------------------------------------------------------------------
  // Bias of 32768 plus 128 for rounding keeps the sums positive; bits [15:8] then equal the
  // floor shift plus the 128 offset, modulo 256.
  logic [16:0]   u_acc, v_acc;
  logic [PW-1:0] cu, cv;
  logic [r2y_pkg::OUT_DATA_W-1:0] out_data_r;
  logic out_user_r, out_last_r;

  always_comb begin
    u_acc = 17'd32896 + 17'd112 * 17'(s2_r.avg_b)
          - 17'd38 * 17'(s2_r.avg_r) - 17'd74 * 17'(s2_r.avg_g);
    v_acc = 17'd32896 + 17'd112 * 17'(s2_r.avg_r)
          - 17'd94 * 17'(s2_r.avg_g) - 17'd18 * 17'(s2_r.avg_b);
    cu = s2_r.chroma ? u_acc[15:8] : '0;
    cv = s2_r.chroma ? v_acc[15:8] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s2_valid_r) begin
      out_data_r <= {cv, cu, s2_r.luma};
      out_user_r <= s2_r.chroma;
      out_last_r <= s2_r.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

// ===== design/r2y_ram.sv =====
// ----------------------------------------------------------------------------
// r2y_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module r2y_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, holds when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== design/r2y_checker.sv =====
// ----------------------------------------------------------------------------
// r2y_checker
// Port-level assertions for the RGB24 to YUV 4:2:0 converter.
// ----------------------------------------------------------------------------
`default_nettype none

module r2y_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_tready,
  input wire logic                           out_tvalid,
  input wire logic                           out_tready,
  input wire logic [r2y_pkg::OUT_DATA_W-1:0] out_tdata,
  input wire logic                           out_tuser,
  input wire logic                           out_tlast
);

  // a stalled result beat keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("result beat changed while stalled");

  // input backpressure only while a finished beat waits downstream
  a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without output stall");

  // U and V read as zero on beats without chroma
  a_no_chroma_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[23:8] == 16'd0)
    else $error("chroma nonzero on a beat without chroma");

  // luma stays within the studio swing
  a_luma_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[7:0] >= 8'd16 && out_tdata[7:0] <= 8'd235)
    else $error("luma out of range");

  // pipeline comes out of reset empty: no result for the first cycles
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> !out_tvalid ##1 !out_tvalid ##1 !out_tvalid)
    else $error("result beat without matching input beat");

endmodule

bind rgb24_to_yuv420_converter r2y_checker u_r2y_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

`default_nettype wire
